### design/dllc_pkg.sv
package dllc_pkg;

  // default sizes
  localparam int NODES_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 64;

  // fixed port widths
  localparam int CMD_W    = 5;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INS_FIRST  = 5'd0;
  localparam logic [CMD_W-1:0] CMD_INS_LAST   = 5'd1;
  localparam logic [CMD_W-1:0] CMD_FIRST      = 5'd2;
  localparam logic [CMD_W-1:0] CMD_LAST       = 5'd3;
  localparam logic [CMD_W-1:0] CMD_GET_FIRST  = 5'd4;
  localparam logic [CMD_W-1:0] CMD_GET_LAST   = 5'd5;
  localparam logic [CMD_W-1:0] CMD_DEL_FIRST  = 5'd6;
  localparam logic [CMD_W-1:0] CMD_DEL_LAST   = 5'd7;
  localparam logic [CMD_W-1:0] CMD_DEL_AFTER  = 5'd8;
  localparam logic [CMD_W-1:0] CMD_DEL_BEFORE = 5'd9;
  localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 5'd10;
  localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 5'd11;
  localparam logic [CMD_W-1:0] CMD_GET        = 5'd12;
  localparam logic [CMD_W-1:0] CMD_SET        = 5'd13;
  localparam logic [CMD_W-1:0] CMD_NEXT       = 5'd14;
  localparam logic [CMD_W-1:0] CMD_PREV       = 5'd15;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 5'd16;

  // status codes
  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD1  = 6'b000010,
    S_RD2  = 6'b000100,
    S_WR1  = 6'b001000,
    S_WR2  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

endpackage

### design/dllc_ram.sv
module dllc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

### design/doubly_linked_list_with_cursor.sv
// channel  | handshake           | payload
// ---------+---------------------+-------------------------------------------
// request  | in_valid / in_stall | cmd, data_in
// result   | out_valid/out_stall | data_out, status, cursor_valid, count
//
// every request steps through accept, two link reads, two link writes,
// and a final state showing the result; each node memory has one read
// port and one write port. a stalled result holds the sequencer,
// and in_stall stays high until the result is taken. synchronous reset
// empties the list at once: node memories need no clearing since free
// slots come from a fill mark and a stack of released slots.
module doubly_linked_list_with_cursor #(
  parameter int NODES       = dllc_pkg::NODES_DEF,
  parameter int VALUE_WIDTH = dllc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dllc_pkg::CMD_W-1:0]     cmd,
  input  logic signed [dllc_pkg::DATA_W-1:0] data_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [dllc_pkg::DATA_W-1:0] data_out,
  output logic [dllc_pkg::STATUS_W-1:0]  status,
  output logic                           cursor_valid,
  output logic [dllc_pkg::COUNT_W-1:0]   count
);
  import dllc_pkg::*;

  // pointer width holds the null code, address width indexes the pool
  localparam int PW = $clog2(NODES + 1);
  localparam int AW = $clog2(NODES);
  localparam logic [PW-1:0] NIL = PW'(NODES);

  function automatic logic is_node(input logic [PW-1:0] p);
    return p < NIL;
  endfunction

  state_t state;

  // latched request
  logic [CMD_W-1:0]       cmd_r;
  logic [VALUE_WIDTH-1:0] data_r;

  // list registers
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [PW-1:0] cur;
  logic [PW-1:0] len;

  // slot allocation: fill mark plus stack of released slots
  logic [PW-1:0] wm;
  logic [PW-1:0] sp;

  // working registers
  logic [PW-1:0]          addr1;
  logic [PW-1:0]          lk1;
  logic [PW-1:0]          nslot;
  logic [VALUE_WIDTH-1:0] dout_r;
  logic [STATUS_W-1:0]    status_r;

  // memory ports
  logic                   val_we, lnk_re, stk_we, stk_re;
  logic [AW-1:0]          val_wa, nxt_wa, prv_wa, stk_wa, lnk_ra, stk_ra;
  logic [VALUE_WIDTH-1:0] val_wd, rv;
  logic                   nxt_we, prv_we;
  logic [PW-1:0]          nxt_wd, prv_wd, stk_wd, rn, rp, rs;

  logic          accept;
  logic [PW-1:0] a1_sel;
  logic [PW-1:0] lk_sel;
  logic          full;
  logic          cur_ok;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign full     = (len == NIL);
  assign cur_ok   = is_node(cur);

  // first read address: the node the request works on
  always_comb begin
    unique case (cmd)
      CMD_GET_FIRST, CMD_DEL_FIRST: a1_sel = head;
      CMD_GET_LAST,  CMD_DEL_LAST:  a1_sel = tail;
      default:                      a1_sel = cur;
    endcase
  end

  // link taken from the first read
  always_comb begin
    unique case (cmd_r)
      CMD_DEL_FIRST, CMD_DEL_AFTER, CMD_INS_AFTER, CMD_NEXT: lk_sel = rn;
      default:                                               lk_sel = rp;
    endcase
  end

  // read side: first read at the target, second read at its neighbor
  assign lnk_re = accept || (state == S_RD1);
  assign lnk_ra = (state == S_RD1) ? lk_sel[AW-1:0] : a1_sel[AW-1:0];
  assign stk_re = accept;
  assign stk_ra = AW'(sp - PW'(1));

  // write side
  always_comb begin
    val_we = 1'b0;
    val_wa = nslot[AW-1:0];
    val_wd = data_r;
    nxt_we = 1'b0;
    nxt_wa = nslot[AW-1:0];
    nxt_wd = NIL;
    prv_we = 1'b0;
    prv_wa = nslot[AW-1:0];
    prv_wd = NIL;
    stk_we = 1'b0;
    stk_wa = sp[AW-1:0];
    stk_wd = head;
    if (state == S_WR1) begin
      unique case (cmd_r)
        CMD_INS_FIRST, CMD_INS_LAST: begin
          // new node gets its value and both links
          if (!full) begin
            val_we = 1'b1;
            nxt_we = 1'b1;
            prv_we = 1'b1;
            nxt_wd = (cmd_r == CMD_INS_FIRST) ? head : NIL;
            prv_wd = (cmd_r == CMD_INS_FIRST) ? NIL : tail;
          end
        end
        CMD_INS_AFTER, CMD_INS_BEFORE: begin
          if (cur_ok && !full) begin
            val_we = 1'b1;
            nxt_we = 1'b1;
            prv_we = 1'b1;
            nxt_wd = (cmd_r == CMD_INS_AFTER) ? lk1 : cur;
            prv_wd = (cmd_r == CMD_INS_AFTER) ? cur : lk1;
          end
        end
        CMD_DEL_FIRST: begin
          if (is_node(head)) begin
            stk_we = 1'b1;
            stk_wd = head;
            prv_we = is_node(lk1);
            prv_wa = lk1[AW-1:0];
            prv_wd = NIL;
          end
        end
        CMD_DEL_LAST: begin
          if (is_node(tail)) begin
            stk_we = 1'b1;
            stk_wd = tail;
            nxt_we = is_node(lk1);
            nxt_wa = lk1[AW-1:0];
            nxt_wd = NIL;
          end
        end
        CMD_DEL_AFTER: begin
          // rn now holds the link past the deleted node
          if (cur_ok && is_node(lk1)) begin
            stk_we = 1'b1;
            stk_wd = lk1;
            nxt_we = 1'b1;
            nxt_wa = cur[AW-1:0];
            nxt_wd = rn;
            prv_we = is_node(rn);
            prv_wa = rn[AW-1:0];
            prv_wd = cur;
          end
        end
        CMD_DEL_BEFORE: begin
          if (cur_ok && is_node(lk1)) begin
            stk_we = 1'b1;
            stk_wd = lk1;
            prv_we = 1'b1;
            prv_wa = cur[AW-1:0];
            prv_wd = rp;
            nxt_we = is_node(rp);
            nxt_wa = rp[AW-1:0];
            nxt_wd = cur;
          end
        end
        CMD_SET: begin
          val_we = cur_ok;
          val_wa = cur[AW-1:0];
        end
        default: begin
        end
      endcase
    end else if (state == S_WR2) begin
      unique case (cmd_r)
        CMD_INS_FIRST: begin
          prv_we = !full && is_node(head);
          prv_wa = head[AW-1:0];
          prv_wd = nslot;
        end
        CMD_INS_LAST: begin
          nxt_we = !full && is_node(tail);
          nxt_wa = tail[AW-1:0];
          nxt_wd = nslot;
        end
        CMD_INS_AFTER: begin
          nxt_we = cur_ok && !full;
          nxt_wa = cur[AW-1:0];
          nxt_wd = nslot;
          prv_we = cur_ok && !full && is_node(lk1);
          prv_wa = lk1[AW-1:0];
          prv_wd = nslot;
        end
        CMD_INS_BEFORE: begin
          prv_we = cur_ok && !full;
          prv_wa = cur[AW-1:0];
          prv_wd = nslot;
          nxt_we = cur_ok && !full && is_node(lk1);
          nxt_wa = lk1[AW-1:0];
          nxt_wd = nslot;
        end
        default: begin
        end
      endcase
    end
  end

  // node memories and the free slot stack
  dllc_ram #(.DEPTH(NODES), .WIDTH(VALUE_WIDTH)) u_val (
    .clk(clk), .we(val_we), .wa(val_wa), .wd(val_wd),
    .re(lnk_re), .ra(lnk_ra), .rd(rv)
  );

  dllc_ram #(.DEPTH(NODES), .WIDTH(PW)) u_nxt (
    .clk(clk), .we(nxt_we), .wa(nxt_wa), .wd(nxt_wd),
    .re(lnk_re), .ra(lnk_ra), .rd(rn)
  );

  dllc_ram #(.DEPTH(NODES), .WIDTH(PW)) u_prv (
    .clk(clk), .we(prv_we), .wa(prv_wa), .wd(prv_wd),
    .re(lnk_re), .ra(lnk_ra), .rd(rp)
  );

  dllc_ram #(.DEPTH(NODES), .WIDTH(PW)) u_stk (
    .clk(clk), .we(stk_we), .wa(stk_wa), .wd(stk_wd),
    .re(stk_re), .ra(stk_ra), .rd(rs)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= cmd;
      data_r   <= data_in[VALUE_WIDTH-1:0];
      addr1    <= a1_sel;
      dout_r   <= '0;
      status_r <= STS_OK;
    end
    if (state == S_RD1) begin
      lk1   <= lk_sel;
      // a released slot first, else the next never-used one
      nslot <= (sp != '0) ? rs : wm;
      if (cmd_r == CMD_GET_FIRST || cmd_r == CMD_GET_LAST || cmd_r == CMD_GET) begin
        if (is_node(addr1)) begin
          dout_r <= rv;
        end else begin
          status_r <= STS_EMPTY;
        end
      end
    end
    if (state == S_WR1) begin
      if (cmd_r == CMD_INS_FIRST || cmd_r == CMD_INS_LAST) begin
        if (full) begin
          status_r <= STS_FULL;
        end
      end
      if (cmd_r == CMD_INS_AFTER || cmd_r == CMD_INS_BEFORE) begin
        if (cur_ok && full) begin
          status_r <= STS_FULL;
        end
      end
    end
  end

  // sequencer and list registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= NIL;
      tail  <= NIL;
      cur   <= NIL;
      len   <= '0;
      wm    <= '0;
      sp    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RD1;
          end
        end
        S_RD1: state <= S_RD2;
        S_RD2: state <= S_WR1;
        S_WR1: begin
          state <= S_WR2;
          unique case (cmd_r)
            CMD_FIRST: cur <= head;
            CMD_LAST:  cur <= tail;
            CMD_DEL_FIRST: begin
              if (is_node(head)) begin
                if (cur == head) begin
                  cur <= NIL;
                end
                head <= lk1;
                if (!is_node(lk1)) begin
                  tail <= NIL;
                end
                sp  <= sp + PW'(1);
                len <= len - PW'(1);
              end
            end
            CMD_DEL_LAST: begin
              if (is_node(tail)) begin
                if (cur == tail) begin
                  cur <= NIL;
                end
                tail <= lk1;
                if (!is_node(lk1)) begin
                  head <= NIL;
                end
                sp  <= sp + PW'(1);
                len <= len - PW'(1);
              end
            end
            CMD_DEL_AFTER: begin
              if (cur_ok && is_node(lk1)) begin
                if (!is_node(rn)) begin
                  tail <= cur;
                end
                sp  <= sp + PW'(1);
                len <= len - PW'(1);
              end
            end
            CMD_DEL_BEFORE: begin
              if (cur_ok && is_node(lk1)) begin
                if (!is_node(rp)) begin
                  head <= cur;
                end
                sp  <= sp + PW'(1);
                len <= len - PW'(1);
              end
            end
            CMD_NEXT, CMD_PREV: begin
              // walking off either end drops the cursor
              if (cur_ok) begin
                cur <= is_node(lk1) ? lk1 : NIL;
              end
            end
            CMD_CLEAR: begin
              head <= NIL;
              tail <= NIL;
              cur  <= NIL;
              len  <= '0;
              wm   <= '0;
              sp   <= '0;
            end
            default: begin
            end
          endcase
        end
        S_WR2: begin
          state <= S_OUT;
          if (!full && ((cmd_r == CMD_INS_FIRST) || (cmd_r == CMD_INS_LAST) ||
              (cur_ok && ((cmd_r == CMD_INS_AFTER) || (cmd_r == CMD_INS_BEFORE))))) begin
            len <= len + PW'(1);
            if (sp != '0) begin
              sp <= sp - PW'(1);
            end else begin
              wm <= wm + PW'(1);
            end
            unique case (cmd_r)
              CMD_INS_FIRST: begin
                if (!is_node(head)) begin
                  tail <= nslot;
                end
                head <= nslot;
              end
              CMD_INS_LAST: begin
                if (!is_node(tail)) begin
                  head <= nslot;
                end
                tail <= nslot;
              end
              CMD_INS_AFTER: begin
                if (!is_node(lk1)) begin
                  tail <= nslot;
                end
              end
              default: begin
                if (!is_node(lk1)) begin
                  head <= nslot;
                end
              end
            endcase
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result, held steady while stalled
  assign out_valid    = (state == S_OUT);
  assign data_out     = DATA_W'($signed(dout_r));
  assign status       = status_r;
  assign cursor_valid = cur_ok;
  assign count        = COUNT_W'(len);

endmodule
